// ----- hw/rtl/mbe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants of the escape-time counter.
// ----------------------------------------------------------------------------
package mbe_pkg;

    // width of the iteration counter and of the limit register
    localparam int ITER_W = 16;

    // limit register value after reset
    localparam logic [ITER_W-1:0] MAX_ITER_RESET = 16'd1000;

    // status returned by the shared multiplier
    typedef struct packed {
        logic done;
        logic ovf;
    } mul_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mbe_point_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_point_if
// Input channel carrying one complex point per beat.
// ----------------------------------------------------------------------------
interface mbe_point_if #(
    parameter int COORD_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] c_real;
    logic [COORD_WIDTH-1:0] c_imag;

    modport source (output valid, output c_real, output c_imag, input ready);
    modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/mbe_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_result_if
// Output channel carrying one escape count per beat.
// ----------------------------------------------------------------------------
interface mbe_result_if;
    logic                      valid;
    logic                      ready;
    logic [mbe_pkg::ITER_W-1:0] iteration_count;
    logic                      reached_limit;

    modport source (output valid, output iteration_count, output reached_limit,
                    input ready);
    modport sink   (input valid, input iteration_count, input reached_limit,
                    output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/mbe_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_mul
// Shared signed fixed-point multiplier. Splits the magnitudes into halves,
// forms four partial products, rounds to nearest (ties away from zero) and
// flags any result outside the coordinate range.
// ----------------------------------------------------------------------------
module mbe_mul #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 28
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [COORD_WIDTH-1:0] a,
    input  wire logic [COORD_WIDTH-1:0] b,
    output logic      [COORD_WIDTH-1:0] result,
    output mbe_pkg::mul_status_t        status
);

    localparam int HALF  = (COORD_WIDTH + 1) / 2;
    localparam int PP_W  = 2 * HALF;
    localparam int ACC_W = 2 * COORD_WIDTH;
    localparam int M_W   = ACC_W - FRAC_BITS;

    localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [M_W-1:0]   VMAX_M =
        {{(M_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } state_t;

    state_t                    state_reg, state_next;
    logic [2:0]                cnt_reg, cnt_next;
    logic [COORD_WIDTH-1:0]    a_mag_reg, a_mag_next;
    logic [COORD_WIDTH-1:0]    b_mag_reg, b_mag_next;
    logic                      neg_reg, neg_next;
    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic [PP_W-1:0]           pp_reg, pp_next;
    logic [1:0]                sel_reg, sel_next;
    logic [COORD_WIDTH-1:0]    result_reg, result_next;
    mbe_pkg::mul_status_t      status_reg, status_next;

    logic [HALF-1:0]           op_a;
    logic [HALF-1:0]           op_b;
    logic [ACC_W-1:0]          pp_ext;
    logic [ACC_W-1:0]          pp_shifted;
    logic [M_W-1:0]            m_val;
    logic [M_W-1:0]            lim;

    // half selection for the current partial product
    always_comb
    begin
        op_a = cnt_reg[1] ? HALF'(a_mag_reg >> HALF) : a_mag_reg[HALF-1:0];
        op_b = cnt_reg[0] ? HALF'(b_mag_reg >> HALF) : b_mag_reg[HALF-1:0];
    end

    // alignment of the registered partial product
    always_comb
    begin
        pp_ext = ACC_W'(pp_reg);
        case (sel_reg) inside
            2'd0:       pp_shifted = pp_ext;
            2'd1, 2'd2: pp_shifted = pp_ext << HALF;
            default:    pp_shifted = pp_ext << (2 * HALF);
        endcase
    end

    // rounded magnitude and range limit
    assign m_val = acc_reg[ACC_W-1:FRAC_BITS];
    assign lim   = VMAX_M + M_W'(neg_reg);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        a_mag_next  = a_mag_reg;
        b_mag_next  = b_mag_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        pp_next     = pp_reg;
        sel_next    = sel_reg;
        result_next = result_reg;
        status_next = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    a_mag_next = a[COORD_WIDTH-1] ? (~a + COORD_WIDTH'(1)) : a;
                    b_mag_next = b[COORD_WIDTH-1] ? (~b + COORD_WIDTH'(1)) : b;
                    neg_next   = a[COORD_WIDTH-1] ^ b[COORD_WIDTH-1];
                    acc_next   = RND;
                    cnt_next   = 3'd0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg != 3'd4)
                begin
                    pp_next  = op_a * op_b;
                    sel_next = cnt_reg[1:0];
                end
                if (cnt_reg != 3'd0)
                begin
                    acc_next = acc_reg + pp_shifted;
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                status_next.done = 1'b1;
                status_next.ovf  = (m_val > lim);
                result_next      = neg_reg ? (~m_val[COORD_WIDTH-1:0] + COORD_WIDTH'(1))
                                           : m_val[COORD_WIDTH-1:0];
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= 3'd0;
            status_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            status_reg <= status_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        a_mag_reg  <= a_mag_next;
        b_mag_reg  <= b_mag_next;
        neg_reg    <= neg_next;
        acc_reg    <= acc_next;
        pp_reg     <= pp_next;
        sel_reg    <= sel_next;
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign status = status_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/mandelbrot_escape_counter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_escape_counter_unit
// Escape-time counter for one complex point: z = c*c + c, then z = z*z + c
// until |z|^2 reaches 4, a value leaves the coordinate range or the limit.
// ----------------------------------------------------------------------------
// A pass is three products on one shared multiplier plus the test, two adds and the
// loop check. Throughput: one point at a time; the next point can be taken in the
// cycle after the result is loaded into the output register, which must be empty
// or being read. Reset clears the control state and loads the iteration limit
// with 1000.
// ----------------------------------------------------------------------------
module mandelbrot_escape_counter_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 28
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    mbe_point_if.sink                       point,
    mbe_result_if.source                    result,
    input  wire logic                       cfg_we,
    input  wire logic [mbe_pkg::ITER_W-1:0] cfg_wdata
);

    localparam int W = COORD_WIDTH;
    localparam logic [W-1:0] FOUR = W'(4) << FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GO,
        ST_WAIT,
        ST_TEST,
        ST_ADD1,
        ST_ADD2,
        ST_LOOP,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        OP_XS,
        OP_YS,
        OP_P
    } op_t;

    // control
    state_t                     state_reg, state_next;
    op_t                        op_reg, op_next;
    logic [mbe_pkg::ITER_W-1:0] iter_reg, iter_next;
    logic [mbe_pkg::ITER_W-1:0] max_reg, max_next;
    logic                       ovf_reg, ovf_next;
    logic                       first_reg, first_next;
    logic                       out_valid_reg, out_valid_next;
    logic [mbe_pkg::ITER_W-1:0] out_count_reg, out_count_next;
    logic                       out_limit_reg, out_limit_next;

    // datapath
    logic [W-1:0]               cr_reg, cr_next;
    logic [W-1:0]               ci_reg, ci_next;
    logic [W-1:0]               x_reg, x_next;
    logic [W-1:0]               y_reg, y_next;
    logic [W-1:0]               xs_reg, xs_next;
    logic [W-1:0]               ys_reg, ys_next;
    logic [W-1:0]               p_reg, p_next;

    // shared multiplier
    logic                       mul_start;
    logic [W-1:0]               mul_a;
    logic [W-1:0]               mul_b;
    logic [W-1:0]               mul_result;
    mbe_pkg::mul_status_t       mul_status;

    // checked adders
    logic [W:0]                 add_y;
    logic [W:0]                 add_x;
    logic [W-1:0]               mag_sum;

    mbe_mul #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .result (mul_result),
        .status (mul_status)
    );

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = x_reg;
        mul_b = x_reg;
        case (op_reg)
            OP_YS:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            OP_P:
            begin
                mul_b = y_reg;
            end
            default:
            begin
                mul_b = x_reg;
            end
        endcase
    end

    // first add: ci + p and cr - ys; second add: + p and + xs
    always_comb
    begin
        if (state_reg == ST_ADD1)
        begin
            add_y = {ci_reg[W-1], ci_reg} + {p_reg[W-1], p_reg};
            add_x = {cr_reg[W-1], cr_reg} - {ys_reg[W-1], ys_reg};
        end
        else
        begin
            add_y = {y_reg[W-1], y_reg} + {p_reg[W-1], p_reg};
            add_x = {x_reg[W-1], x_reg} + {xs_reg[W-1], xs_reg};
        end
    end

    // squared magnitude, both terms non-negative
    assign mag_sum = xs_reg + ys_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        iter_next      = iter_reg;
        max_next       = max_reg;
        ovf_next       = ovf_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        out_limit_next = out_limit_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        xs_next        = xs_reg;
        ys_next        = ys_reg;
        p_next         = p_reg;
        mul_start      = 1'b0;

        // limit register write
        if (cfg_we)
        begin
            max_next = cfg_wdata;
        end

        // output beat taken
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (point.valid)
                begin
                    cr_next    = point.c_real;
                    ci_next    = point.c_imag;
                    x_next     = point.c_real;
                    y_next     = point.c_imag;
                    iter_next  = '0;
                    ovf_next   = 1'b0;
                    first_next = 1'b1;
                    op_next    = OP_XS;
                    state_next = ST_GO;
                end
            end
            ST_GO:
            begin
                mul_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mul_status.done)
                begin
                    ovf_next = ovf_reg | mul_status.ovf;
                    unique case (op_reg)
                        OP_XS:
                        begin
                            xs_next    = mul_result;
                            op_next    = OP_YS;
                            state_next = ST_GO;
                        end
                        OP_YS:
                        begin
                            ys_next    = mul_result;
                            state_next = ST_TEST;
                        end
                        default:
                        begin
                            p_next     = mul_result;
                            state_next = ST_ADD1;
                        end
                    endcase
                end
            end
            ST_TEST:
            begin
                if (!first_reg && (ovf_reg || (mag_sum >= FOUR)))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    if (!first_reg)
                    begin
                        iter_next = iter_reg + 1'b1;
                    end
                    op_next    = OP_P;
                    state_next = ST_GO;
                end
            end
            ST_ADD1:
            begin
                y_next     = add_y[W-1:0];
                x_next     = add_x[W-1:0];
                ovf_next   = ovf_reg | (add_y[W] ^ add_y[W-1]) | (add_x[W] ^ add_x[W-1]);
                state_next = ST_ADD2;
            end
            ST_ADD2:
            begin
                y_next     = add_y[W-1:0];
                x_next     = add_x[W-1:0];
                ovf_next   = ovf_reg | (add_y[W] ^ add_y[W-1]) | (add_x[W] ^ add_x[W-1]);
                state_next = ST_LOOP;
            end
            ST_LOOP:
            begin
                first_next = 1'b0;
                if ((iter_reg < max_reg) && !ovf_reg)
                begin
                    op_next    = OP_XS;
                    state_next = ST_GO;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = iter_reg;
                    out_limit_next = (iter_reg == max_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_XS;
            iter_reg      <= '0;
            max_reg       <= mbe_pkg::MAX_ITER_RESET;
            ovf_reg       <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_count_reg <= '0;
            out_limit_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            iter_reg      <= iter_next;
            max_reg       <= max_next;
            ovf_reg       <= ovf_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
            out_count_reg <= out_count_next;
            out_limit_reg <= out_limit_next;
        end
    end

    // coordinate registers
    always_ff @(posedge clk)
    begin
        cr_reg <= cr_next;
        ci_reg <= ci_next;
        x_reg  <= x_next;
        y_reg  <= y_next;
        xs_reg <= xs_next;
        ys_reg <= ys_next;
        p_reg  <= p_next;
    end

    // channel outputs
    assign point.ready            = (state_reg == ST_IDLE);
    assign result.valid           = out_valid_reg;
    assign result.iteration_count = out_count_reg;
    assign result.reached_limit   = out_limit_reg;

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the escape-time counter. Points are sent through the
// point channel with random gaps, and results are taken with random stalls on
// the result channel. A fixed-point predictor in the bench works out the
// iteration count and the limit flag of every point, and each result beat is
// checked against the oldest prediction. The first phase uses the reset limit, and
// the register is then rewritten to zero, one, the maximum and small settings.
// ----------------------------------------------------------------------------
module testbench;

    localparam int     ITER_W     = mbe_pkg::ITER_W;
    localparam int     COORD_W    = 32;
    localparam int     FRAC_W     = 28;
    localparam longint COORD_MAX  = 64'sd2147483647;
    localparam longint COORD_MIN  = -64'sd2147483648;
    localparam longint FOUR_Q     = 64'sd4 <<< FRAC_W;
    localparam longint HALF_LSB   = 64'sd1 <<< (FRAC_W - 1);
    localparam int     SETTLE_CYC = 8;
    localparam int     STUCK_MAX  = 150000;
    localparam int     SWEEP_ITEMS = 560;

    // a few Q4.28 values used by the directed points
    localparam logic [COORD_W-1:0] Q_ZERO     = 32'h0000_0000;
    localparam logic [COORD_W-1:0] Q_ONE      = 32'h1000_0000;
    localparam logic [COORD_W-1:0] Q_NEG_ONE  = 32'hF000_0000;
    localparam logic [COORD_W-1:0] Q_ONE_HALF = 32'h1800_0000;
    localparam logic [COORD_W-1:0] Q_TWO      = 32'h2000_0000;
    localparam logic [COORD_W-1:0] Q_NEG_TWO  = 32'hE000_0000;
    localparam logic [COORD_W-1:0] Q_TWO_HALF = 32'h2800_0000;
    localparam logic [COORD_W-1:0] Q_QUARTER  = 32'h0400_0000;
    localparam logic [COORD_W-1:0] Q_HALF     = 32'h0800_0000;
    localparam logic [COORD_W-1:0] Q_MAX      = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] Q_MIN      = 32'h8000_0000;

    typedef struct packed {
        logic [ITER_W-1:0] iteration_count;
        logic              reached_limit;
    } escape_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [ITER_W-1:0] cfg_wdata;

    mbe_point_if #(.COORD_WIDTH(COORD_W)) point_ch ();
    mbe_result_if result_ch ();

    escape_result_t expected_escapes[$];
    logic [ITER_W-1:0] iter_limit;
    int  error_count;
    bit  no_gaps;
    int  stuck_cycles;

    mandelbrot_escape_counter_unit #(
        .COORD_WIDTH(COORD_W),
        .FRAC_BITS  (FRAC_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .point    (point_ch),
        .result   (result_ch),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // rounded fixed-point product, returns 1 on overflow
    function automatic bit fx_mul(input longint a, input longint b, output longint r);
        longint ma;
        longint mb;
        longint m;
        longint lim;
        bit     neg;
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        neg = (a < 0) != (b < 0);
        m   = (ma * mb + HALF_LSB) >>> FRAC_W;
        lim = neg ? -COORD_MIN : COORD_MAX;
        if (m > lim)
        begin
            r = 0;
            return 1'b1;
        end
        r = neg ? -m : m;
        return 1'b0;
    endfunction

    // range-checked sum and difference
    function automatic bit fx_add(input longint a, input longint b, output longint r);
        longint s;
        s = a + b;
        if (s > COORD_MAX || s < COORD_MIN)
        begin
            r = 0;
            return 1'b1;
        end
        r = s;
        return 1'b0;
    endfunction

    function automatic bit fx_sub(input longint a, input longint b, output longint r);
        longint s;
        s = a - b;
        if (s > COORD_MAX || s < COORD_MIN)
        begin
            r = 0;
            return 1'b1;
        end
        r = s;
        return 1'b0;
    endfunction

    // escape count of one point under a given limit
    function automatic escape_result_t predict_escape(input logic [COORD_W-1:0] cr_bits,
                                                      input logic [COORD_W-1:0] ci_bits,
                                                      input logic [ITER_W-1:0] limit);
        longint cr;
        longint ci;
        longint x;
        longint y;
        longint xs;
        longint ys;
        longint p;
        longint t;
        bit     ovf;
        int unsigned n;
        escape_result_t res;
        cr  = longint'($signed(cr_bits));
        ci  = longint'($signed(ci_bits));
        ovf = 1'b0;
        n   = 0;
        // first step z = c*c + c
        ovf |= fx_mul(cr, cr, xs);
        ovf |= fx_mul(ci, ci, ys);
        ovf |= fx_mul(cr, ci, p);
        ovf |= fx_sub(cr, ys, t);
        ovf |= fx_add(t, xs, x);
        ovf |= fx_add(ci, p, t);
        ovf |= fx_add(t, p, y);
        // z = z*z + c until escape, overflow or limit
        while (n < limit && !ovf)
        begin
            ovf |= fx_mul(x, x, xs);
            ovf |= fx_mul(y, y, ys);
            if (ovf || xs + ys >= FOUR_Q)
                break;
            n++;
            ovf |= fx_mul(x, y, p);
            ovf |= fx_add(ci, p, t);
            ovf |= fx_add(t, p, y);
            ovf |= fx_sub(cr, ys, t);
            ovf |= fx_add(t, xs, x);
        end
        res.iteration_count = n[ITER_W-1:0];
        res.reached_limit   = (n == limit);
        return res;
    endfunction

    // gap length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    // send one point beat and record its prediction on acceptance
    task automatic send_point(input logic [COORD_W-1:0] cr, input logic [COORD_W-1:0] ci);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            point_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_ch.valid  <= 1'b1;
        point_ch.c_real <= cr;
        point_ch.c_imag <= ci;
        do
            @(posedge clk);
        while (!point_ch.ready);
        expected_escapes.push_back(predict_escape(cr, ci, iter_limit));
    endtask

    // write the limit register once the block has drained
    task automatic write_limit(input logic [ITER_W-1:0] value);
        point_ch.valid <= 1'b0;
        while (expected_escapes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        iter_limit  = value;
    endtask

    // point in the window around the set: real -2.5..1.5, imag -1.5..1.5
    task automatic region_point(output logic [COORD_W-1:0] cr, output logic [COORD_W-1:0] ci);
        int re;
        int im;
        re = int'($urandom_range(0, 1073741824)) - 671088640;
        im = int'($urandom_range(0, 805306368)) - 402653184;
        cr = re;
        ci = im;
    endtask

    // mostly window points, the rest raw bit patterns
    task automatic send_mixed();
        logic [COORD_W-1:0] cr;
        logic [COORD_W-1:0] ci;
        if ($urandom_range(0, 99) < 80)
            region_point(cr, ci);
        else
        begin
            cr = $urandom;
            ci = $urandom;
        end
        send_point(cr, ci);
    endtask

    // window point that escapes within cap iterations
    task automatic send_escaping(input int cap);
        logic [COORD_W-1:0] cr;
        logic [COORD_W-1:0] ci;
        escape_result_t     trial;
        do
        begin
            region_point(cr, ci);
            trial = predict_escape(cr, ci, ITER_W'(cap + 1));
        end
        while (trial.iteration_count > cap);
        send_point(cr, ci);
    endtask

    // reset limit, slow points inside the set and overflow cases
    task automatic test_reset_limit();
        iter_limit = mbe_pkg::MAX_ITER_RESET;
        send_point(Q_ZERO, Q_ZERO);
        send_point(Q_NEG_ONE, Q_ZERO);
        send_point(Q_NEG_TWO, Q_ZERO);
        send_point(Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MIN);
        send_point(Q_TWO_HALF, Q_ZERO);
        send_point(Q_ONE_HALF, Q_TWO);
        repeat (12) send_mixed();
    endtask

    // zero limit: count 0 with the flag set, whatever the point
    task automatic test_zero_limit();
        write_limit('0);
        send_point(Q_ZERO, Q_ZERO);
        send_point(Q_NEG_TWO, Q_ZERO);
        send_point(Q_MAX, Q_MIN);
        repeat (10) send_mixed();
    endtask

    // limit of one with no idling; rounding ties on the product
    task automatic test_limit_one();
        no_gaps = 1'b1;
        write_limit(ITER_W'(1));
        send_point(32'h0000_4000, 32'h0000_2000);
        send_point(32'hFFFF_C000, 32'h0000_2000);
        send_point(32'h0000_4000, 32'hFFFF_E000);
        send_point(Q_QUARTER, Q_ZERO);
        send_point(Q_TWO, Q_ZERO);
        send_point(Q_ZERO, Q_TWO);
        repeat (20) send_mixed();
        no_gaps = 1'b0;
    endtask

    // largest limit, only points that escape early
    task automatic test_limit_max();
        write_limit('1);
        send_point(Q_NEG_TWO, Q_ZERO);
        send_point(Q_TWO_HALF, Q_ZERO);
        send_point(Q_HALF, Q_HALF);
        send_point(Q_ONE, Q_ONE);
        repeat (30) send_escaping(40);
    endtask

    // random points over a series of small limits
    task automatic test_random_sweep();
        logic [ITER_W-1:0] limits[8];
        limits = '{ITER_W'(2), ITER_W'(3), ITER_W'(8), ITER_W'(16),
                   ITER_W'(31), ITER_W'(48), ITER_W'(5), ITER_W'(12)};
        foreach (limits[i])
        begin
            if (i == 7)
                write_limit(ITER_W'($urandom_range(1, 48)));
            else
                write_limit(limits[i]);
            no_gaps = (i == 3);
            repeat (SWEEP_ITEMS / 8) send_mixed();
        end
        no_gaps = 1'b0;
    endtask

    // result side: random stalls and the check of each beat
    initial
    begin
        int hold_left;
        escape_result_t want;
        result_ch.ready <= 1'b0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_escapes.size() == 0)
                begin
                    $error("result beat with no point outstanding: count %0d, flag %0d",
                           result_ch.iteration_count, result_ch.reached_limit);
                    error_count++;
                end
                else
                begin
                    want = expected_escapes.pop_front();
                    if (result_ch.iteration_count !== want.iteration_count)
                    begin
                        $error("iteration_count: expected %0d, actual %0d",
                               want.iteration_count, result_ch.iteration_count);
                        error_count++;
                    end
                    if (result_ch.reached_limit !== want.reached_limit)
                    begin
                        $error("reached_limit: expected %0d, actual %0d",
                               want.reached_limit, result_ch.reached_limit);
                        error_count++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                hold_left = pick_gap();
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_MAX)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        point_ch.valid  <= 1'b0;
        point_ch.c_real <= '0;
        point_ch.c_imag <= '0;
        error_count  = 0;
        no_gaps      = 1'b0;
        stuck_cycles = 0;
        iter_limit   = mbe_pkg::MAX_ITER_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_limit();
        test_zero_limit();
        test_limit_one();
        test_limit_max();
        test_random_sweep();

        // drain and let the block settle
        point_ch.valid <= 1'b0;
        while (expected_escapes.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/mbe_pkg.sv
hw/rtl/mbe_point_if.sv
hw/rtl/mbe_result_if.sv
hw/rtl/mbe_mul.sv
hw/rtl/mandelbrot_escape_counter_unit.sv
test/testbench.sv
